// ----- hdl/isr_pkg.sv -----
`timescale 1ns / 1ps

package isr_pkg;

	// number of cells in the sorting chain
	localparam int CAPACITY = 64;

	// one stored record
	typedef struct packed {
		logic [39:0] key_high;
		logic [63:0] key_low;
		logic [15:0] handle;
		logic [7:0]  class_number;
	} rec_t;

	// incoming request payload
	typedef struct packed {
		logic [39:0] key_high;
		logic [63:0] key_low;
		logic [15:0] payload_handle;
		logic [7:0]  class_number;
		logic        last_in;
	} req_t;

	// sorted result payload
	typedef struct packed {
		logic [39:0] sorted_key_high;
		logic [63:0] sorted_key_low;
		logic [15:0] sorted_handle;
		logic [7:0]  sorted_class;
		logic        last_out;
		logic        overflow;
	} res_t;

	// chain-wide control
	typedef struct packed {
		logic insert;
		logic shift;
	} ctl_t;

endpackage

// ----- hdl/isr_cell.sv -----
`timescale 1ns / 1ps

module isr_cell
	import isr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  ctl_t ctl,
	input  rec_t new_rec,
	input  rec_t left_rec,
	input  logic left_valid,
	input  logic left_greater,
	input  rec_t right_rec,
	input  logic right_valid,
	output rec_t rec,
	output logic valid,
	output logic greater
);

	rec_t rec_q;
	logic valid_q;
	logic take_left;
	logic take_new;

	// held key strictly above the incoming key
	assign greater = valid_q &&
		({rec_q.key_high, rec_q.key_low} > {new_rec.key_high, new_rec.key_low});

	// insertion: shift right behind a larger neighbour, or take the new record
	assign take_left = ctl.insert && left_greater;
	assign take_new  = ctl.insert && !left_greater &&
		(greater || (!valid_q && left_valid));

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= right_valid;
		end else if (take_left || take_new) begin
			valid_q <= 1'b1;
		end
	end

	// record contents
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			rec_q <= right_rec;
		end else if (take_left) begin
			rec_q <= left_rec;
		end else if (take_new) begin
			rec_q <= new_rec;
		end
	end

	assign rec   = rec_q;
	assign valid = valid_q;

endmodule

// ----- hdl/insertion_sort_records.sv -----
`timescale 1ns / 1ps
// Stable insertion sort of records by a 104-bit text key, ascending.
// Request channel (req_valid / req_stall / req_data): one record per cycle
// while loading. Each record is placed into a chain of CAPACITY cells in the
// cycle it is accepted; the compare against the new key sits in every cell.
// Equal keys keep arrival order. A record arriving with the chain full is
// dropped and the batch is marked with overflow.
// A request carrying last_in ends the batch. From the next cycle the chain
// drains through cell 0: one result per cycle on sorted_valid / sorted_stall
// / sorted_data, N results for N stored records, last_out on the final one.
// During the drain req_stall is high, so a batch is loaded in full before it
// drains; one record per cycle each way while that side is not stalled.
// A stall on the result side holds the chain and the current result.
// After the final result is taken the chain is empty and loading resumes.
// Reset empties every cell, clears the overflow mark and ends any drain.
module insertion_sort_records
	import isr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic sorted_valid,
	input  logic sorted_stall,
	output res_t sorted_data
);

	rec_t                cell_rec [CAPACITY];
	logic [CAPACITY-1:0] cell_valid;
	logic [CAPACITY-1:0] cell_greater;
	rec_t                new_rec;
	ctl_t                ctl;
	logic                draining_q;
	logic                overflow_q;
	logic                req_accept;
	logic                res_accept;
	logic                full;

	assign new_rec.key_high     = req_data.key_high;
	assign new_rec.key_low      = req_data.key_low;
	assign new_rec.handle       = req_data.payload_handle;
	assign new_rec.class_number = req_data.class_number;

	// handshakes
	assign req_stall    = draining_q;
	assign req_accept   = req_valid && !req_stall;
	assign sorted_valid = draining_q;
	assign res_accept   = sorted_valid && !sorted_stall;
	assign full         = cell_valid[CAPACITY-1];

	assign ctl.insert = req_accept && !full;
	assign ctl.shift  = res_accept;

	// the chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rec_t l_rec;
		logic l_valid;
		logic l_greater;
		rec_t r_rec;
		logic r_valid;

		if (i == 0) begin : g_head
			assign l_rec     = new_rec;
			assign l_valid   = 1'b1;
			assign l_greater = 1'b0;
		end else begin : g_mid
			assign l_rec     = cell_rec[i-1];
			assign l_valid   = cell_valid[i-1];
			assign l_greater = cell_greater[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_rec   = new_rec;
			assign r_valid = 1'b0;
		end else begin : g_body
			assign r_rec   = cell_rec[i+1];
			assign r_valid = cell_valid[i+1];
		end

		isr_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.new_rec      (new_rec),
			.left_rec     (l_rec),
			.left_valid   (l_valid),
			.left_greater (l_greater),
			.right_rec    (r_rec),
			.right_valid  (r_valid),
			.rec          (cell_rec[i]),
			.valid        (cell_valid[i]),
			.greater      (cell_greater[i])
		);
	end

	// batch control: drain after last_in, overflow mark per batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			overflow_q <= 1'b0;
		end else if (res_accept && !cell_valid[1]) begin
			draining_q <= 1'b0;
			overflow_q <= 1'b0;
		end else if (req_accept) begin
			if (full) begin
				overflow_q <= 1'b1;
			end
			if (req_data.last_in) begin
				draining_q <= 1'b1;
			end
		end
	end

	// result taken straight from the head cell
	assign sorted_data.sorted_key_high = cell_rec[0].key_high;
	assign sorted_data.sorted_key_low  = cell_rec[0].key_low;
	assign sorted_data.sorted_handle   = cell_rec[0].handle;
	assign sorted_data.sorted_class    = cell_rec[0].class_number;
	assign sorted_data.last_out        = !cell_valid[1];
	assign sorted_data.overflow        = overflow_q;

`ifndef NO_ASSERTIONS
	// a drain always has a record at the head
	a_drain_head: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> cell_valid[0])
		else $error("drain with empty head cell");

	// occupied cells form an unbroken run from the head
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid + 1'b1) & cell_valid) == '0)
		else $error("gap in the cell chain");

	// taking the final result leaves the chain empty and loading
	a_empty_after: assert property (@(posedge clk) disable iff (!arst_n)
		(res_accept && sorted_data.last_out) |=> (cell_valid == '0 && !draining_q))
		else $error("chain not empty after final result");
`endif

endmodule
